// ===== src/instance_slot_map_draw_list_assert.svh =====
`ifndef INSTANCE_SLOT_MAP_DRAW_LIST_ASSERT_SVH
`define INSTANCE_SLOT_MAP_DRAW_LIST_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define ISMDL_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define ISMDL_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ismdl_pkg.sv =====
package ismdl_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_ADD,
        ST_DEL,
        ST_SCAN,
        ST_EMIT
    } t_state;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_DEL   = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_BUILD = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    // most commands one build may emit
    localparam int MAX_CMDS = 16;

    typedef struct packed {
        logic [3:0]  mat;
        logic        live;
        logic [31:0] gen;
    } t_slot_rec;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot_out;
        logic [31:0] generation;
        logic [31:0] index_count;
        logic [10:0] instance_count;
        logic [31:0] first_index;
        logic [31:0] vertex_offset;
        logic [10:0] first_instance;
        logic        last;
    } t_result;

endpackage

// ===== src/instance_slot_map_draw_list.sv =====
// Channel  Dir  Accept          Fields
// command  in   start & !busy   i_opcode i_slot i_material i_mesh_indices i_mesh_vertices
// result   out  o_strobe        o_status o_slot_out o_generation ... o_first_instance o_last
// config   in   i_cfg_we        i_cfg_data (material_count)
//
// Steps: load, fresh-slot add, full add and out-of-range delete answer from the accept alone;
// in-range delete does slot read, write back; add from the free stack does stack read, slot
// read, write back. Build: accept, one slot-table read per cycle on the single read port,
// the last read, one beat per material. Reset (i_rst_n low, synchronous) clears the fill
// count and stack depth; slots at or above slots_used are never read, so there is no
// clearing pass. The receiver cannot stall.
module instance_slot_map_draw_list #(
    parameter int SLOTS     = 1024,
    parameter int MATERIALS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [9:0]  i_slot,
    input  logic [3:0]  i_material,
    input  logic [31:0] i_mesh_indices,
    input  logic [31:0] i_mesh_vertices,

    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,

    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [9:0]  o_slot_out,
    output logic [31:0] o_generation,
    output logic [31:0] o_index_count,
    output logic [10:0] o_instance_count,
    output logic [31:0] o_first_index,
    output logic [31:0] o_vertex_offset,
    output logic [10:0] o_first_instance,
    output logic        o_last
);

    // slot index, fill count, material lanes, command count
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (CW > 10) ? CW : 10;
    localparam int L  = (MATERIALS < ismdl_pkg::MAX_CMDS) ? MATERIALS : ismdl_pkg::MAX_CMDS;
    localparam int LW = (L > 1) ? $clog2(L) : 1;
    localparam int MW = $clog2(L + 1);

    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    ismdl_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_depth, n_depth;
    logic [4:0]    r_cfg;
    logic [MW-1:0] r_n, n_n;
    logic [MW-1:0] r_m, n_m;
    logic [CW-1:0] r_i, n_i;
    logic          r_cnt_en, n_cnt_en;
    logic [3:0]    r_op_mat, n_op_mat;
    logic [SW-1:0] r_op_slot, n_op_slot;

    logic [10:0]   r_cnt [L];
    logic [10:0]   n_cnt [L];
    logic [31:0]   r_mesh_idx [L];
    logic [31:0]   r_mesh_vtx [L];
    logic [31:0]   r_sum_idx, n_sum_idx;
    logic [31:0]   r_sum_vtx, n_sum_vtx;
    logic [10:0]   r_sum_inst, n_sum_inst;

    logic                r_strobe, n_strobe;
    ismdl_pkg::t_result  r_res, n_res;

    // slot table and free stack
    ismdl_pkg::t_slot_rec r_slot_mem [SLOTS];
    ismdl_pkg::t_slot_rec r_rec_q;
    logic [SW-1:0]        r_free_mem [SLOTS];
    logic [SW-1:0]        r_free_q;

    logic                 rec_re, rec_we;
    logic [SW-1:0]        rec_raddr, rec_waddr;
    ismdl_pkg::t_slot_rec rec_wdata;
    logic                 fs_re, fs_we;
    logic [SW-1:0]        fs_raddr, fs_waddr;
    logic [SW-1:0]        fs_wdata;
    logic                 mesh_we;
    logic [LW-1:0]        mesh_waddr;

    logic          accept;
    logic [MW-1:0] eff_n;
    logic          del_in_range;
    logic          scan_more;
    logic          emit_last;
    logic [31:0]   slot_wide;

    assign busy     = (r_state != ismdl_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign del_in_range = (XW'(i_slot) < XW'(r_used));
    assign scan_more    = (r_i < r_used);
    assign emit_last    = (r_m == (r_n - MW'(1)));

    // material_count: zero acts as one, large values clamp to the lane count
    always_comb begin
        if (r_cfg == 5'd0) begin
            eff_n = MW'(1);
        end else if (32'(r_cfg) > 32'(L)) begin
            eff_n = MW'(L);
        end else begin
            eff_n = MW'(r_cfg);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ismdl_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        ismdl_pkg::OP_ADD: begin
                            if (r_depth != '0) n_state = ismdl_pkg::ST_POP;
                        end
                        ismdl_pkg::OP_DEL: begin
                            if (del_in_range) n_state = ismdl_pkg::ST_DEL;
                        end
                        ismdl_pkg::OP_LOAD:  n_state = ismdl_pkg::ST_IDLE;
                        ismdl_pkg::OP_BUILD: n_state = ismdl_pkg::ST_SCAN;
                    endcase
                end
            end
            ismdl_pkg::ST_POP:  n_state = ismdl_pkg::ST_ADD;
            ismdl_pkg::ST_ADD:  n_state = ismdl_pkg::ST_IDLE;
            ismdl_pkg::ST_DEL:  n_state = ismdl_pkg::ST_IDLE;
            ismdl_pkg::ST_SCAN: begin
                if (!scan_more && !r_cnt_en) n_state = ismdl_pkg::ST_EMIT;
            end
            ismdl_pkg::ST_EMIT: begin
                if (emit_last) n_state = ismdl_pkg::ST_IDLE;
            end
            default: n_state = ismdl_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_used     = r_used;
        n_depth    = r_depth;
        n_n        = r_n;
        n_m        = r_m;
        n_i        = r_i;
        n_cnt_en   = 1'b0;
        n_op_mat   = r_op_mat;
        n_op_slot  = r_op_slot;
        n_sum_idx  = r_sum_idx;
        n_sum_vtx  = r_sum_vtx;
        n_sum_inst = r_sum_inst;
        n_cnt      = r_cnt;
        n_strobe   = 1'b0;
        n_res      = '0;
        n_res.last = 1'b1;
        slot_wide  = '0;

        rec_re    = 1'b0;
        rec_raddr = '0;
        rec_we    = 1'b0;
        rec_waddr = '0;
        rec_wdata = '0;
        fs_re     = 1'b0;
        fs_raddr  = '0;
        fs_we     = 1'b0;
        fs_waddr  = '0;
        fs_wdata  = '0;
        mesh_we   = 1'b0;
        mesh_waddr = '0;

        // lane counters take the word that the scan read in the cycle before
        if (r_cnt_en && r_rec_q.live) begin
            for (int k = 0; k < L; k++) begin
                if (32'(r_rec_q.mat) == k) n_cnt[k] = r_cnt[k] + 11'd1;
            end
        end

        unique case (r_state)
            ismdl_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        ismdl_pkg::OP_ADD: begin
                            n_op_mat = i_material;
                            if (r_depth != '0) begin
                                fs_re    = 1'b1;
                                fs_raddr = SW'(r_depth - CW'(1));
                                n_depth  = r_depth - CW'(1);
                            end else if (r_used < SLOTS_C) begin
                                // fresh slot: generation is still zero
                                rec_we         = 1'b1;
                                rec_waddr      = SW'(r_used);
                                rec_wdata.mat  = i_material;
                                rec_wdata.live = 1'b1;
                                rec_wdata.gen  = '0;
                                n_used         = r_used + CW'(1);
                                slot_wide      = 32'(r_used);
                                n_strobe       = 1'b1;
                                n_res.status   = ismdl_pkg::STAT_OK;
                                n_res.slot_out = slot_wide[9:0];
                            end else begin
                                n_strobe     = 1'b1;
                                n_res.status = ismdl_pkg::STAT_FULL;
                            end
                        end
                        ismdl_pkg::OP_DEL: begin
                            if (del_in_range) begin
                                rec_re    = 1'b1;
                                rec_raddr = SW'(i_slot);
                                n_op_slot = SW'(i_slot);
                            end else begin
                                n_strobe     = 1'b1;
                                n_res.status = ismdl_pkg::STAT_IGNORED;
                            end
                        end
                        ismdl_pkg::OP_LOAD: begin
                            // loads of unknown materials still answer ok
                            if (32'(i_material) < 32'(L)) begin
                                mesh_we    = 1'b1;
                                mesh_waddr = i_material[LW-1:0];
                            end
                            n_strobe     = 1'b1;
                            n_res.status = ismdl_pkg::STAT_OK;
                        end
                        ismdl_pkg::OP_BUILD: begin
                            n_n        = eff_n;
                            n_m        = '0;
                            n_i        = '0;
                            n_sum_idx  = '0;
                            n_sum_vtx  = '0;
                            n_sum_inst = '0;
                            for (int k = 0; k < L; k++) n_cnt[k] = '0;
                        end
                    endcase
                end
            end
            ismdl_pkg::ST_POP: begin
                n_op_slot = r_free_q;
                rec_re    = 1'b1;
                rec_raddr = r_free_q;
            end
            ismdl_pkg::ST_ADD: begin
                rec_we           = 1'b1;
                rec_waddr        = r_op_slot;
                rec_wdata.mat    = r_op_mat;
                rec_wdata.live   = 1'b1;
                rec_wdata.gen    = r_rec_q.gen;
                slot_wide        = 32'(r_op_slot);
                n_strobe         = 1'b1;
                n_res.status     = ismdl_pkg::STAT_OK;
                n_res.slot_out   = slot_wide[9:0];
                n_res.generation = r_rec_q.gen;
            end
            ismdl_pkg::ST_DEL: begin
                n_strobe = 1'b1;
                if (!r_rec_q.live) begin
                    n_res.status = ismdl_pkg::STAT_IGNORED;
                end else begin
                    rec_we         = 1'b1;
                    rec_waddr      = r_op_slot;
                    rec_wdata.mat  = r_rec_q.mat;
                    rec_wdata.live = 1'b0;
                    rec_wdata.gen  = r_rec_q.gen + 32'd1;
                    if (r_depth < SLOTS_C) begin
                        fs_we    = 1'b1;
                        fs_waddr = SW'(r_depth);
                        fs_wdata = r_op_slot;
                        n_depth  = r_depth + CW'(1);
                    end
                    n_res.status = ismdl_pkg::STAT_OK;
                end
            end
            ismdl_pkg::ST_SCAN: begin
                if (scan_more) begin
                    rec_re    = 1'b1;
                    rec_raddr = SW'(r_i);
                    n_i       = r_i + CW'(1);
                    n_cnt_en  = 1'b1;
                end
            end
            ismdl_pkg::ST_EMIT: begin
                n_strobe             = 1'b1;
                n_res.status         = ismdl_pkg::STAT_OK;
                n_res.index_count    = r_mesh_idx[r_m[LW-1:0]];
                n_res.instance_count = r_cnt[r_m[LW-1:0]];
                n_res.first_index    = r_sum_idx;
                n_res.vertex_offset  = r_sum_vtx;
                n_res.first_instance = r_sum_inst;
                n_res.last           = emit_last;
                n_sum_idx            = r_sum_idx + r_mesh_idx[r_m[LW-1:0]];
                n_sum_vtx            = r_sum_vtx + r_mesh_vtx[r_m[LW-1:0]];
                n_sum_inst           = r_sum_inst + r_cnt[r_m[LW-1:0]];
                n_m                  = r_m + MW'(1);
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ismdl_pkg::ST_IDLE;
            r_used   <= '0;
            r_depth  <= '0;
            r_cfg    <= 5'd1;
            r_cnt_en <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_depth  <= n_depth;
            r_cnt_en <= n_cnt_en;
            r_strobe <= n_strobe;
            if (i_cfg_we) r_cfg <= i_cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_m        <= n_m;
        r_i        <= n_i;
        r_op_mat   <= n_op_mat;
        r_op_slot  <= n_op_slot;
        r_sum_idx  <= n_sum_idx;
        r_sum_vtx  <= n_sum_vtx;
        r_sum_inst <= n_sum_inst;
        r_cnt      <= n_cnt;
        r_res      <= n_res;
    end

    // mesh size tables reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) begin
                r_mesh_idx[k] <= '0;
                r_mesh_vtx[k] <= '0;
            end
        end else if (mesh_we) begin
            r_mesh_idx[mesh_waddr] <= i_mesh_indices;
            r_mesh_vtx[mesh_waddr] <= i_mesh_vertices;
        end
    end

    // slot table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (rec_we) r_slot_mem[rec_waddr] <= rec_wdata;
        if (rec_re) r_rec_q <= r_slot_mem[rec_raddr];
    end

    // free stack: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (fs_we) r_free_mem[fs_waddr] <= fs_wdata;
        if (fs_re) r_free_q <= r_free_mem[fs_raddr];
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_res.status;
    assign o_slot_out       = r_res.slot_out;
    assign o_generation     = r_res.generation;
    assign o_index_count    = r_res.index_count;
    assign o_instance_count = r_res.instance_count;
    assign o_first_index    = r_res.first_index;
    assign o_vertex_offset  = r_res.vertex_offset;
    assign o_first_instance = r_res.first_instance;
    assign o_last           = r_res.last;

endmodule

// ===== src/ismdl_checker.sv =====
`include "instance_slot_map_draw_list_assert.svh"

module ismdl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_opcode,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic [9:0]  o_slot_out,
    input logic [31:0] o_generation,
    input logic        o_last
);

    logic err_beat;
    logic full_beat;
    logic no_slot;
    logic load_cmd;
    logic load_beat;

    assign err_beat  = o_strobe && (o_status != ismdl_pkg::STAT_OK);
    assign full_beat = o_strobe && (o_status == ismdl_pkg::STAT_FULL);
    assign no_slot   = (o_slot_out == 10'd0) && (o_generation == 32'd0);
    assign load_cmd  = start && !busy && (i_opcode == ismdl_pkg::OP_LOAD);
    assign load_beat = o_strobe && o_last && (o_status == ismdl_pkg::STAT_OK);

    // a build's beats come back to back
    `ISMDL_AST_NEXT(a_run_contiguous, o_strobe && !o_last, o_strobe, "build run broken")

    // error answers are single beats
    `ISMDL_AST_NOW(a_err_single, err_beat, o_last, "error beat not last")

    // a full table gives no slot
    `ISMDL_AST_NOW(a_full_zero, full_beat, no_slot, "full add carries a slot")

    // load answers on the next cycle
    `ISMDL_AST_NEXT(a_load_next, load_cmd, load_beat, "load beat missing")

    // the block stays busy until the last beat of a run
    `ISMDL_AST_NOW(a_busy_in_run, o_strobe && !o_last, busy, "new command taken mid run")

endmodule

bind instance_slot_map_draw_list ismdl_checker u_ismdl_checker (.*);

// ===== bench/instance_slot_map_draw_list_tb.sv =====
module instance_slot_map_draw_list_tb;

    localparam int SLOT_TOTAL = 1024;
    localparam int MAT_TOTAL  = 16;
    // a build never emits more beats than this
    localparam int CMD_LIMIT  = (MAT_TOTAL < ismdl_pkg::MAX_CMDS) ? MAT_TOTAL
                                                                 : ismdl_pkg::MAX_CMDS;
    // watchdog, in clock cycles: several times the slowest legal run
    localparam int WATCHDOG_CYCLES = 400000;
    // random commands per phase
    localparam int PHASE_CMDS = 40;

    // ------------------------------------------------------------------
    // Shadow of the slot table, free stack and mesh tables. Every accepted
    // command is folded in here and the beats it must produce are queued.
    // ------------------------------------------------------------------
    class slot_map_model;
        bit [3:0]    slot_mat   [SLOT_TOTAL];
        bit          slot_live  [SLOT_TOTAL];
        bit [31:0]   slot_gen   [SLOT_TOTAL];
        bit [9:0]    free_stack [SLOT_TOTAL];
        int unsigned free_depth;
        int unsigned slots_used;
        bit [31:0]   mesh_idx   [MAT_TOTAL];
        bit [31:0]   mesh_vtx   [MAT_TOTAL];
        bit [4:0]    material_count;
        ismdl_pkg::t_result pending_beats[$];
        int          failures;
        int          beats_checked;
        int          full_answers;
        int          ignored_dels;
        int          cfg_writes;
        int          op_counts[4];

        function new();
            material_count = 5'd1;
        endfunction

        function void note_config(bit [4:0] value);
            material_count = value;
            cfg_writes++;
        endfunction

        function void expect_beat(ismdl_pkg::t_result b);
            pending_beats.insert(pending_beats.size(), b);
        endfunction

        // random slot below the fill mark with the wanted live state
        function bit pick_slot(bit want_live, output bit [9:0] s);
            int unsigned k;
            s = '0;
            if (slots_used == 0)
                return 0;
            for (k = 0; k < 16; k++) begin
                s = 10'($urandom_range(slots_used - 1));
                if (slot_live[s] == want_live)
                    return 1;
            end
            for (k = 0; k < slots_used; k++) begin
                if (slot_live[k] == want_live) begin
                    s = k[9:0];
                    return 1;
                end
            end
            return 0;
        endfunction

        function void note_command(bit [1:0] op, bit [9:0] s, bit [3:0] m,
                                   bit [31:0] ni, bit [31:0] nv);
            ismdl_pkg::t_result b;
            int unsigned idx;
            int unsigned n;
            int unsigned k;
            bit [10:0]   counts[ismdl_pkg::MAX_CMDS];
            bit [31:0]   run_index;
            bit [31:0]   run_vertex;
            bit [10:0]   run_inst;

            b = '0;
            b.last = 1'b1;
            op_counts[op]++;
            case (op)
                ismdl_pkg::OP_ADD: begin
                    if (free_depth > 0) begin
                        free_depth--;
                        idx = free_stack[free_depth];
                    end else if (slots_used < SLOT_TOTAL) begin
                        idx = slots_used;
                        slots_used++;
                    end else begin
                        idx = SLOT_TOTAL;
                    end
                    if (idx == SLOT_TOTAL) begin
                        b.status = ismdl_pkg::STAT_FULL;
                        full_answers++;
                    end else begin
                        slot_mat[idx]  = m;
                        slot_live[idx] = 1'b1;
                        b.status       = ismdl_pkg::STAT_OK;
                        b.slot_out     = idx[9:0];
                        b.generation   = slot_gen[idx];
                    end
                    expect_beat(b);
                end
                ismdl_pkg::OP_DEL: begin
                    // out of range or already free: answer ignored, no change
                    if (s >= slots_used || !slot_live[s]) begin
                        b.status = ismdl_pkg::STAT_IGNORED;
                        ignored_dels++;
                    end else begin
                        slot_gen[s]  = slot_gen[s] + 32'd1;
                        slot_live[s] = 1'b0;
                        free_stack[free_depth] = s;
                        free_depth++;
                        b.status = ismdl_pkg::STAT_OK;
                    end
                    expect_beat(b);
                end
                ismdl_pkg::OP_LOAD: begin
                    if (m < MAT_TOTAL) begin
                        mesh_idx[m] = ni;
                        mesh_vtx[m] = nv;
                    end
                    b.status = ismdl_pkg::STAT_OK;
                    expect_beat(b);
                end
                ismdl_pkg::OP_BUILD: begin
                    // zero acts as one, anything past the limit clamps
                    if (material_count == 0)
                        n = 1;
                    else if (material_count > CMD_LIMIT)
                        n = CMD_LIMIT;
                    else
                        n = material_count;
                    counts = '{default: '0};
                    for (k = 0; k < slots_used; k++) begin
                        if (slot_live[k] && slot_mat[k] < n)
                            counts[slot_mat[k]]++;
                    end
                    run_index  = '0;
                    run_vertex = '0;
                    run_inst   = '0;
                    for (k = 0; k < n; k++) begin
                        b = '0;
                        b.status         = ismdl_pkg::STAT_OK;
                        b.index_count    = mesh_idx[k];
                        b.instance_count = counts[k];
                        b.first_index    = run_index;
                        b.vertex_offset  = run_vertex;
                        b.first_instance = run_inst;
                        b.last           = (k + 1 == n);
                        expect_beat(b);
                        run_index  += mesh_idx[k];
                        run_vertex += mesh_vtx[k];
                        run_inst   += counts[k];
                    end
                end
            endcase
        endfunction

        function string beat_text(ismdl_pkg::t_result r);
            return {$sformatf("st=%0d slot=%0d gen=%h idx=%h ",
                              r.status, r.slot_out, r.generation, r.index_count),
                    $sformatf("inst=%0d fidx=%h voff=%h finst=%0d last=%b",
                              r.instance_count, r.first_index, r.vertex_offset,
                              r.first_instance, r.last)};
        endfunction

        function void check_beat(ismdl_pkg::t_result got);
            ismdl_pkg::t_result want;
            string   bad;
            beats_checked++;
            if (pending_beats.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("beat %0d arrived with nothing expected: %s",
                             beats_checked, beat_text(got));
            end else begin
                want = pending_beats.pop_front();
                bad  = "";
                if (got.status         !== want.status)         bad = {bad, " status"};
                if (got.slot_out       !== want.slot_out)       bad = {bad, " slot_out"};
                if (got.generation     !== want.generation)     bad = {bad, " generation"};
                if (got.index_count    !== want.index_count)    bad = {bad, " index_count"};
                if (got.instance_count !== want.instance_count) bad = {bad, " instance_count"};
                if (got.first_index    !== want.first_index)    bad = {bad, " first_index"};
                if (got.vertex_offset  !== want.vertex_offset)  bad = {bad, " vertex_offset"};
                if (got.first_instance !== want.first_instance) bad = {bad, " first_instance"};
                if (got.last           !== want.last)           bad = {bad, " last"};
                if (bad != "") begin
                    failures++;
                    if (failures <= 10) begin
                        $display("beat %0d mismatch in%s", beats_checked, bad);
                        $display("  expected %s", beat_text(want));
                        $display("  actual   %s", beat_text(got));
                    end
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup. All inputs start at known values.
    // ------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode        = '0;
    logic [9:0]  i_slot          = '0;
    logic [3:0]  i_material      = '0;
    logic [31:0] i_mesh_indices  = '0;
    logic [31:0] i_mesh_vertices = '0;
    logic        i_cfg_we        = 1'b0;
    logic [4:0]  i_cfg_data      = '0;

    logic        o_strobe;
    logic [1:0]  o_status;
    logic [9:0]  o_slot_out;
    logic [31:0] o_generation;
    logic [31:0] o_index_count;
    logic [10:0] o_instance_count;
    logic [31:0] o_first_index;
    logic [31:0] o_vertex_offset;
    logic [10:0] o_first_instance;
    logic        o_last;

    slot_map_model model = new();

    always #4 i_clk = ~i_clk;

    instance_slot_map_draw_list #(
        .SLOTS     (SLOT_TOTAL),
        .MATERIALS (MAT_TOTAL)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_slot           (i_slot),
        .i_material       (i_material),
        .i_mesh_indices   (i_mesh_indices),
        .i_mesh_vertices  (i_mesh_vertices),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_slot_out       (o_slot_out),
        .o_generation     (o_generation),
        .o_index_count    (o_index_count),
        .o_instance_count (o_instance_count),
        .o_first_index    (o_first_index),
        .o_vertex_offset  (o_vertex_offset),
        .o_first_instance (o_first_instance),
        .o_last           (o_last)
    );

    // Result monitor: a beat is taken at every edge that sees the strobe high.
    // Values read here are pre-edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            model.check_beat(ismdl_pkg::t_result'{o_status, o_slot_out, o_generation,
                                                  o_index_count, o_instance_count,
                                                  o_first_index, o_vertex_offset,
                                                  o_first_instance, o_last});
    end

    // ------------------------------------------------------------------
    // Driver tasks. Each is entered right after a rising edge and returns
    // right after one. start stays high on return so back-to-back commands go
    // out with no bubble; idle_gap and settle are what drop it.
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic [1:0] op, input logic [9:0] s, input logic [3:0] m,
                            input logic [31:0] ni, input logic [31:0] nv);
        start           <= 1'b1;
        i_opcode        <= op;
        i_slot          <= s;
        i_material      <= m;
        i_mesh_indices  <= ni;
        i_mesh_vertices <= nv;
        // accepted at the first edge that sees busy low
        do
            @(posedge i_clk);
        while (busy);
        model.note_command(op, s, m, ni, nv);
    endtask

    // random sender gap, pct chances in a hundred
    task automatic idle_gap(input int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    // hold off until every queued beat has come back and the block is idle
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (model.pending_beats.size() != 0 || busy);
    endtask

    task automatic write_material_count(input logic [4:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        model.note_config(value);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] mesh_size();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal traffic: adds, deletes of live slots, mesh loads and the
    // odd build, with some deletes of free or out-of-range slots and raw noise.
    task automatic random_cmd();
        int         r;
        bit [9:0]   s;
        r = $urandom_range(99);
        if (r < 35) begin
            send_cmd(ismdl_pkg::OP_ADD, 10'($urandom_range(1023)), 4'($urandom_range(15)),
                     $urandom, $urandom);
        end else if (r < 60) begin
            if (model.pick_slot(1'b1, s))
                send_cmd(ismdl_pkg::OP_DEL, s, 4'($urandom_range(15)), $urandom, $urandom);
            else
                send_cmd(ismdl_pkg::OP_ADD, 10'($urandom_range(1023)),
                         4'($urandom_range(15)), $urandom, $urandom);
        end else if (r < 67) begin
            send_cmd(ismdl_pkg::OP_DEL, 10'($urandom_range(1023)), 4'($urandom_range(15)),
                     $urandom, $urandom);
        end else if (r < 73) begin
            // double delete: a slot already on the free stack
            if (!model.pick_slot(1'b0, s))
                s = 10'($urandom_range(1023));
            send_cmd(ismdl_pkg::OP_DEL, s, 4'($urandom_range(15)), $urandom, $urandom);
        end else if (r < 88) begin
            send_cmd(ismdl_pkg::OP_LOAD, 10'($urandom_range(1023)), 4'($urandom_range(15)),
                     mesh_size(), mesh_size());
        end else if (r < 94) begin
            send_cmd(ismdl_pkg::OP_BUILD, 10'($urandom_range(1023)), 4'($urandom_range(15)),
                     $urandom, $urandom);
        end else begin
            send_cmd(2'($urandom_range(3)), 10'($urandom_range(1023)),
                     4'($urandom_range(15)), $urandom, $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    int       idle_plan[4] = '{0, 58, 0, 34};
    int       cfg_plan[6]  = '{16, 0, 31, 5, 17, 0};

    initial begin
        int       ph;
        int       k;
        int       total;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-table build and deletes, extreme mesh sizes, fresh
        // and reused slots, double delete, out-of-range delete. material_count
        // still at its reset value here.
        send_cmd(ismdl_pkg::OP_BUILD, 10'd0,    4'd0,  '0, '0);
        send_cmd(ismdl_pkg::OP_DEL,   10'd0,    4'd0,  '0, '0);
        send_cmd(ismdl_pkg::OP_DEL,   10'd1023, 4'd15, '1, '1);
        send_cmd(ismdl_pkg::OP_LOAD,  10'd0,    4'd0,  '1, '1);
        send_cmd(ismdl_pkg::OP_LOAD,  10'd0,    4'd15, '0, '0);
        send_cmd(ismdl_pkg::OP_LOAD,  10'd0,    4'd1,  $urandom, $urandom);
        send_cmd(ismdl_pkg::OP_LOAD,  10'd0,    4'd2,  32'h8000_0001, 32'h7fff_ffff);
        send_cmd(ismdl_pkg::OP_ADD,   10'd0,    4'd0,  '0, '0);
        send_cmd(ismdl_pkg::OP_ADD,   10'd0,    4'd15, '0, '0);
        send_cmd(ismdl_pkg::OP_ADD,   10'd0,    4'd1,  '0, '0);
        send_cmd(ismdl_pkg::OP_DEL,   10'd1,    4'd0,  '0, '0);
        idle_gap(100);
        send_cmd(ismdl_pkg::OP_DEL,   10'd1,    4'd0,  '0, '0);   // slot already free
        send_cmd(ismdl_pkg::OP_ADD,   10'd0,    4'd3,  '0, '0);   // reuses slot 1, gen 1
        send_cmd(ismdl_pkg::OP_DEL,   10'd2,    4'd0,  '0, '0);
        send_cmd(ismdl_pkg::OP_DEL,   10'd0,    4'd0,  '0, '0);
        idle_gap(100);
        send_cmd(ismdl_pkg::OP_ADD,   10'd0,    4'd9,  '0, '0);   // pops slot 0 first
        send_cmd(ismdl_pkg::OP_ADD,   10'd0,    4'd6,  '0, '0);
        send_cmd(ismdl_pkg::OP_DEL,   10'd3,    4'd0,  '0, '0);   // past the fill mark
        send_cmd(ismdl_pkg::OP_BUILD, 10'd0,    4'd0,  '0, '0);

        // Random phases, each with a material_count write and a sender idling level.
        for (ph = 0; ph < 6; ph++) begin
            settle();
            write_material_count((ph == 5) ? 5'($urandom_range(31)) : 5'(cfg_plan[ph]));
            for (k = 0; k < PHASE_CMDS; k++) begin
                random_cmd();
                if ($urandom_range(24) == 0)
                    settle();
                else
                    idle_gap(idle_plan[ph % 4]);
            end
        end

        // Closing build over every material lane.
        settle();
        write_material_count(5'd16);
        send_cmd(ismdl_pkg::OP_BUILD, 10'd0, 4'd0, '0, '0);

        // Drain, then a short quiet window to catch stray beats.
        settle();
        repeat (64) @(posedge i_clk);
        if (model.pending_beats.size() != 0) begin
            model.failures++;
            $display("%0d expected beats never arrived", model.pending_beats.size());
        end

        total = model.op_counts[0] + model.op_counts[1] + model.op_counts[2]
              + model.op_counts[3];
        $display("ran %0d commands: %0d add, %0d delete, %0d load, %0d build; %0d beats",
                 total, model.op_counts[ismdl_pkg::OP_ADD], model.op_counts[ismdl_pkg::OP_DEL],
                 model.op_counts[ismdl_pkg::OP_LOAD], model.op_counts[ismdl_pkg::OP_BUILD],
                 model.beats_checked);
        $display("table-full answers %0d, ignored deletes %0d, material_count writes %0d",
                 model.full_answers, model.ignored_dels, model.cfg_writes);
        if (model.failures == 0)
            $display("[instance_slot_map_draw_list] OK");
        else
            $display("[instance_slot_map_draw_list] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        repeat (WATCHDOG_CYCLES) @(posedge i_clk);
        $display("[instance_slot_map_draw_list] ERROR");
        $finish;
    end

endmodule
